// File: rtl/core/fsdt_pkg.sv
// shared types and constants of the finite-state transducer
`default_nettype none
package fsdt_pkg;

  // translation bytes carried by one table entry
  localparam int unsigned DataBytes = 4;
  localparam int unsigned ByteIdxW  = 2;

  // request kinds
  typedef enum logic [1:0] {
    REQ_WR_ENTRY = 2'd0,
    REQ_WR_FLAG  = 2'd1,
    REQ_SYMBOL   = 2'd2,
    REQ_EOW      = 2'd3
  } fsdt_req_e;

  // result kinds
  localparam logic KindSymbol  = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_MATCH,
    ST_EMIT,
    ST_VERDICT
  } fsdt_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic rd_row;
    logic wr_row;
    logic wr_flag;
    logic take_hit;
    logic emit_sym;
    logic emit_verdict;
  } fsdt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    fsdt_req_e req;
    logic      in_valid;
    logic      entry_ok;
    logic      flag_ok;
    logic      rejected;
    logic      hit;
    logic      len_zero;
    logic      emit_last;
    logic      out_free;
  } fsdt_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/fsdt_in_if.sv
// input request channel of the transducer
`default_nettype none
interface fsdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  state_index;
  logic [2:0]  slot_index;
  logic        entry_valid;
  logic [7:0]  symbol;
  logic [3:0]  dest_state;
  logic [2:0]  trans_len;
  logic [31:0] trans_data;
  logic        final_flag;

  modport source (
    output valid, req_type, state_index, slot_index, entry_valid, symbol,
           dest_state, trans_len, trans_data, final_flag,
    input  ready
  );
  modport sink (
    input  valid, req_type, state_index, slot_index, entry_valid, symbol,
           dest_state, trans_len, trans_data, final_flag,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/fsdt_out_if.sv
// result channel of the transducer
`default_nettype none
interface fsdt_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_symbol;
  logic        accepted;
  logic [15:0] total_symbols;
  logic        last;

  modport source (
    output valid, out_kind, out_symbol, accepted, total_symbols, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_symbol, accepted, total_symbols, last,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/fsdt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module fsdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fsdt_ctrl.sv
// controller state machine of the transducer
`default_nettype none
module fsdt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fsdt_pkg::fsdt_sts_t sts_i,
  output fsdt_pkg::fsdt_cmd_t      cmd_o
);
  import fsdt_pkg::*;

  fsdt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts_i.req)
          REQ_WR_ENTRY: begin
            if (sts_i.entry_ok) begin
              cmd_o.rd_row = 1'b1;
              state_d      = ST_WRITE;
            end else begin
              state_d = ST_IDLE;
            end
          end
          REQ_WR_FLAG: begin
            cmd_o.wr_flag = sts_i.flag_ok;
            state_d       = ST_IDLE;
          end
          REQ_SYMBOL: begin
            if (sts_i.rejected) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.rd_row = 1'b1;
              state_d      = ST_MATCH;
            end
          end
          REQ_EOW: state_d = ST_VERDICT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        cmd_o.wr_row = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_MATCH: begin
        cmd_o.take_hit = 1'b1;
        if (!sts_i.hit || sts_i.len_zero) state_d = ST_IDLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sym = 1'b1;
          if (sts_i.emit_last) state_d = ST_IDLE;
        end
      end
      ST_VERDICT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_verdict = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/fsdt_dp.sv
// datapath: table memory, slot compare, word state and output register
`default_nettype none
module fsdt_dp #(
  parameter int unsigned NUM_STATES      = 16,
  parameter int unsigned SLOTS_PER_STATE = 8,
  parameter int unsigned MAX_TRANS_LEN   = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fsdt_in_if.sink                  in_i,
  fsdt_out_if.source               out_o,
  input  wire fsdt_pkg::fsdt_cmd_t cmd_i,
  output fsdt_pkg::fsdt_sts_t      sts_o
);
  import fsdt_pkg::*;

  localparam int unsigned Cap  = (MAX_TRANS_LEN < DataBytes) ? MAX_TRANS_LEN : DataBytes;
  localparam int unsigned SW   = $clog2(NUM_STATES);
  localparam int unsigned LW   = $clog2(Cap + 1);
  localparam int unsigned EW   = 1 + 8 + SW + LW + 32;
  localparam int unsigned RowW = EW * SLOTS_PER_STATE;
  localparam int unsigned LenLo  = 32;
  localparam int unsigned DestLo = 32 + LW;
  localparam int unsigned SymLo  = 32 + LW + SW;

  // latched request
  fsdt_req_e   req_q;
  logic [3:0]  st_q;
  logic [2:0]  sl_q;
  logic        ev_q;
  logic [7:0]  sym_q;
  logic [3:0]  dst_q;
  logic [2:0]  tlen_q;
  logic [31:0] tdata_q;
  logic        ff_q;

  // word state
  logic [SW-1:0]       cur_q;
  logic                rej_q;
  logic [15:0]         cnt_q;
  logic [NUM_STATES-1:0] final_q;
  logic [NUM_STATES-1:0] row_vld_q;
  logic                rv_q;

  // taken transition
  logic [SW-1:0]       ent_dest_q;
  logic [LW-1:0]       ent_len_q;
  logic [31:0]         ent_data_q;
  logic [ByteIdxW-1:0] j_q;

  // output register
  logic        out_vld_q;
  logic        okind_q;
  logic [7:0]  osym_q;
  logic        oacc_q;
  logic [15:0] otot_q;
  logic        olast_q;

  logic            accept;
  logic [SW-1:0]   wr_state;
  logic [SW-1:0]   raddr;
  logic [RowW-1:0] rdata;
  logic [RowW-1:0] wrow;
  logic [EW-1:0]   new_ent;
  logic            hit;
  logic [EW-1:0]   hit_ent;
  logic            out_free;
  logic            emit_last;
  logic [15:0]     cnt_inc;
  logic [SW-1:0]   dst_sat;
  logic [LW-1:0]   len_sat;

  assign accept   = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;
  assign wr_state = SW'(st_q);
  assign raddr    = (req_q == REQ_SYMBOL) ? cur_q : wr_state;
  assign out_free = !out_vld_q || out_o.ready;
  assign cnt_inc  = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
  assign emit_last = (32'(j_q) + 32'd1) == 32'(ent_len_q);

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= fsdt_req_e'(in_i.req_type);
      st_q    <= in_i.state_index;
      sl_q    <= in_i.slot_index;
      ev_q    <= in_i.entry_valid;
      sym_q   <= in_i.symbol;
      dst_q   <= in_i.dest_state;
      tlen_q  <= in_i.trans_len;
      tdata_q <= in_i.trans_data;
      ff_q    <= in_i.final_flag;
    end
  end

  // transition table, one row of slots per state
  fsdt_ram #(
    .WIDTH(RowW),
    .DEPTH(NUM_STATES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_row),
    .waddr_i(wr_state),
    .wdata_i(wrow),
    .re_i   (cmd_i.rd_row),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // new entry with saturated destination and length
  assign dst_sat = (32'(dst_q) < NUM_STATES) ? SW'(dst_q) : SW'(NUM_STATES - 1);
  assign len_sat = (32'(tlen_q) < Cap) ? LW'(tlen_q) : LW'(Cap);
  assign new_ent = {ev_q, sym_q, dst_sat, len_sat, tdata_q};

  // row merge; a never-written row reads as empty
  always_comb begin
    for (int k = 0; k < SLOTS_PER_STATE; k++) begin
      if (32'(k) == 32'(sl_q)) wrow[k*EW +: EW] = new_ent;
      else if (rv_q)           wrow[k*EW +: EW] = rdata[k*EW +: EW];
      else                     wrow[k*EW +: EW] = '0;
    end
  end

  // first matching slot of the row
  always_comb begin
    hit     = 1'b0;
    hit_ent = '0;
    for (int k = SLOTS_PER_STATE - 1; k >= 0; k--) begin
      if (rv_q && rdata[k*EW + EW - 1] && rdata[k*EW + SymLo +: 8] == sym_q) begin
        hit     = 1'b1;
        hit_ent = rdata[k*EW +: EW];
      end
    end
  end

  // row valid bits and final flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      final_q   <= '0;
      rv_q      <= 1'b0;
    end else begin
      if (cmd_i.rd_row) rv_q <= row_vld_q[raddr];
      if (cmd_i.wr_row) row_vld_q[wr_state] <= 1'b1;
      if (cmd_i.wr_flag) final_q[wr_state] <= ff_q;
    end
  end

  // taken transition capture and byte index
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_hit) begin
      ent_dest_q <= hit_ent[DestLo +: SW];
      ent_len_q  <= hit_ent[LenLo +: LW];
      ent_data_q <= hit_ent[31:0];
      j_q        <= '0;
    end else if (cmd_i.emit_sym) begin
      j_q <= j_q + 1'b1;
    end
  end

  // current state, rejection and symbol count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      rej_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.take_hit) begin
      if (!hit) rej_q <= 1'b1;
      else if (hit_ent[LenLo +: LW] == '0) cur_q <= hit_ent[DestLo +: SW];
    end else if (cmd_i.emit_sym) begin
      cnt_q <= cnt_inc;
      if (emit_last) cur_q <= ent_dest_q;
    end else if (cmd_i.emit_verdict) begin
      cur_q <= '0;
      rej_q <= 1'b0;
      cnt_q <= '0;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_sym || cmd_i.emit_verdict) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sym) begin
      okind_q <= KindSymbol;
      osym_q  <= ent_data_q[{j_q, 3'b000} +: 8];
      oacc_q  <= 1'b0;
      otot_q  <= cnt_inc;
      olast_q <= emit_last;
    end else if (cmd_i.emit_verdict) begin
      okind_q <= KindVerdict;
      osym_q  <= '0;
      oacc_q  <= !rej_q && final_q[cur_q];
      otot_q  <= cnt_q;
      olast_q <= 1'b1;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_kind      = okind_q;
  assign out_o.out_symbol    = osym_q;
  assign out_o.accepted      = oacc_q;
  assign out_o.total_symbols = otot_q;
  assign out_o.last          = olast_q;

  // status
  always_comb begin
    sts_o           = '0;
    sts_o.req       = req_q;
    sts_o.in_valid  = in_i.valid;
    sts_o.entry_ok  = (32'(st_q) < NUM_STATES) && (32'(sl_q) < SLOTS_PER_STATE);
    sts_o.flag_ok   = 32'(st_q) < NUM_STATES;
    sts_o.rejected  = rej_q;
    sts_o.hit       = hit;
    sts_o.len_zero  = hit_ent[LenLo +: LW] == '0;
    sts_o.emit_last = emit_last;
    sts_o.out_free  = out_free;
  end

endmodule
`default_nettype wire

// File: rtl/core/table_driven_finite_state_transducer.sv
// Table write: accept, row read, row write back. Flag write, and a word
// symbol after rejection: accept, decode. Word symbol: accept, row read,
// match, then the translation symbols in order. End of word: accept,
// decode, verdict. The table memory read and the single output register
// set these steps. Reset clears the current state, the rejection flag, the
// count, final flags and the per-state row valid bits.
`default_nettype none
module table_driven_finite_state_transducer #(
  parameter int unsigned NUM_STATES      = 16,
  parameter int unsigned SLOTS_PER_STATE = 8,
  parameter int unsigned MAX_TRANS_LEN   = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fsdt_in_if.sink    in_i,
  fsdt_out_if.source out_o
);
  import fsdt_pkg::*;

  fsdt_cmd_t cmd;
  fsdt_sts_t sts;

  // controller
  fsdt_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath
  fsdt_dp #(
    .NUM_STATES     (NUM_STATES),
    .SLOTS_PER_STATE(SLOTS_PER_STATE),
    .MAX_TRANS_LEN  (MAX_TRANS_LEN)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule
`default_nettype wire

// File: bench/fsdt_tb_pkg.sv
// scoreboard and result types of the transducer testbench
package fsdt_tb_pkg;
  import fsdt_pkg::*;

  // one expected result of the transducer
  typedef struct packed {
    logic        kind;
    logic [7:0]  sym;
    logic        acc;
    logic [15:0] total;
    logic        last;
  } fsdt_result_t;

  // one stored transition slot
  typedef struct packed {
    logic        valid;
    logic [7:0]  sym;
    logic [3:0]  dest;
    logic [2:0]  len;
    logic [31:0] data;
  } fsdt_slot_t;

  // mirror of the transducer state, checks results against its predictions
  class transducer_scoreboard;
    fsdt_slot_t   slots [16][8];
    logic         finals [16];
    logic [3:0]   cur;
    logic         rej;
    logic [15:0]  count;
    fsdt_result_t pending [$];
    int           errors;

    function new();
      foreach (slots[s, k]) slots[s][k] = '0;
      foreach (finals[s]) finals[s] = 1'b0;
      cur = '0;
      rej = 1'b0;
      count = '0;
      errors = 0;
    endfunction

    // advance the mirror on one accepted request
    function void note_request(fsdt_req_e req, logic [3:0] st, logic [2:0] sl, logic ev,
                               logic [7:0] sym, logic [3:0] dst, logic [2:0] tlen,
                               logic [31:0] tdata, logic ff);
      int hit;
      fsdt_result_t r;
      hit = -1;
      case (req)
        REQ_WR_ENTRY: begin
          slots[st][sl].valid = ev;
          slots[st][sl].sym = sym;
          slots[st][sl].dest = dst;
          slots[st][sl].len = (tlen > 3'd4) ? 3'd4 : tlen;
          slots[st][sl].data = tdata;
        end
        REQ_WR_FLAG: finals[st] = ff;
        REQ_SYMBOL: begin
          if (!rej) begin
            for (int k = 0; k < 8; k++)
              if (hit < 0 && slots[cur][k].valid && slots[cur][k].sym == sym) hit = k;
            if (hit < 0) begin
              rej = 1'b1;
            end else begin
              for (int j = 0; j < slots[cur][hit].len; j++) begin
                if (count != 16'hFFFF) count++;
                r.kind = KindSymbol;
                r.sym = slots[cur][hit].data[8*j +: 8];
                r.acc = 1'b0;
                r.total = count;
                r.last = (j + 1 == slots[cur][hit].len);
                pending.push_back(r);
              end
              cur = slots[cur][hit].dest;
            end
          end
        end
        default: begin
          r.kind = KindVerdict;
          r.sym = '0;
          r.acc = !rej && finals[cur];
          r.total = count;
          r.last = 1'b1;
          pending.push_back(r);
          cur = '0;
          rej = 1'b0;
          count = '0;
        end
      endcase
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(fsdt_result_t got);
      fsdt_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d sym=%0h", got.kind, got.sym);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("out_kind exp %0d got %0d", exp.kind, got.kind); errors++;
      end
      if (got.sym !== exp.sym) begin
        $error("out_symbol exp %0h got %0h", exp.sym, got.sym); errors++;
      end
      if (got.acc !== exp.acc) begin
        $error("accepted exp %0d got %0d", exp.acc, got.acc); errors++;
      end
      if (got.total !== exp.total) begin
        $error("total_symbols exp %0d got %0d", exp.total, got.total); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass
endpackage

// File: bench/table_driven_finite_state_transducer_tb.sv
// testbench of the table-driven finite-state transducer
module table_driven_finite_state_transducer_tb;
  import fsdt_pkg::*;
  import fsdt_tb_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  fsdt_in_if  req_ch ();
  fsdt_out_if res_ch ();

  table_driven_finite_state_transducer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (res_ch.source)
  );

  transducer_scoreboard board;
  int  cycles;
  bit  calm;          // no idling in the last part
  bit  hold_results;  // long receiver hold-off

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: sample at rising edge, random ready bursts
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready)
        board.check_result('{res_ch.out_kind, res_ch.out_symbol, res_ch.accepted,
                             res_ch.total_symbols, res_ch.last});
      @(negedge clk_i);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap - 1) begin
          @(posedge clk_i);
          @(negedge clk_i);
        end
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // offer one request and wait for its acceptance; valid stays up until the
  // next request or an explicit pause drops it
  task automatic send_request(fsdt_req_e req, logic [3:0] st, logic [2:0] sl, logic ev,
                              logic [7:0] sym, logic [3:0] dst, logic [2:0] tlen,
                              logic [31:0] tdata, logic ff);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= req;
    req_ch.state_index <= st;
    req_ch.slot_index <= sl;
    req_ch.entry_valid <= ev;
    req_ch.symbol <= sym;
    req_ch.dest_state <= dst;
    req_ch.trans_len <= tlen;
    req_ch.trans_data <= tdata;
    req_ch.final_flag <= ff;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(req, st, sl, ev, sym, dst, tlen, tdata, ff);
    @(negedge clk_i);
  endtask

  task automatic write_entry(int st, int sl, logic ev, int sym, int dst, int tlen,
                             logic [31:0] tdata);
    send_request(REQ_WR_ENTRY, 4'(st), 3'(sl), ev, 8'(sym), 4'(dst), 3'(tlen), tdata,
                 1'($urandom_range(0, 1)));
  endtask

  task automatic word_symbol(int sym);
    send_request(REQ_SYMBOL, 4'($urandom), 3'($urandom), 1'($urandom), 8'(sym),
                 4'($urandom), 3'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic end_word();
    send_request(REQ_EOW, 4'($urandom), 3'($urandom), 1'($urandom), 8'($urandom),
                 4'($urandom), 3'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // symbol drawn mostly from those stored in the current state
  function automatic int likely_symbol();
    int k;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 5) != 0 && board.slots[board.cur][k].valid)
      return board.slots[board.cur][k].sym;
    return $urandom_range(0, 255);
  endfunction

  // stimulus
  initial begin : stimulus
    int n;
    bit stalled;
    bit paused;
    board = new();
    cycles = 0;
    calm = 0;
    hold_results = 0;
    stalled = 0;
    paused = 0;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WR_ENTRY;
    req_ch.state_index = '0;
    req_ch.slot_index = '0;
    req_ch.entry_valid = 1'b0;
    req_ch.symbol = '0;
    req_ch.dest_state = '0;
    req_ch.trans_len = '0;
    req_ch.trans_data = '0;
    req_ch.final_flag = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, empty and long translations, duplicates, rejection
    write_entry(0, 0, 1, 8'h00, 15, 4, 32'hFFFF_FFFF);
    write_entry(0, 7, 1, 8'hFF, 1, 7, 32'h0403_0201);
    write_entry(0, 3, 1, 8'hFF, 2, 1, 32'h0000_00AA);  // shadowed by slot 7? no: slot 3 first
    write_entry(1, 0, 1, 8'h10, 0, 0, 32'h1234_5678);
    write_entry(15, 5, 1, 8'h00, 0, 2, 32'h0000_BEEF);
    write_entry(15, 6, 0, 8'h01, 3, 3, 32'h00C0_FFEE);
    send_request(REQ_WR_FLAG, 15, 0, 0, 0, 0, 0, 0, 1'b1);
    send_request(REQ_WR_FLAG, 1, 0, 0, 0, 0, 0, 0, 1'b1);
    word_symbol(8'h00);
    word_symbol(8'h00);
    end_word();
    word_symbol(8'hFF);
    end_word();
    word_symbol(8'h01);
    word_symbol(8'h00);
    end_word();
    end_word();
    send_request(REQ_WR_FLAG, 15, 0, 0, 0, 0, 0, 0, 1'b0);
    word_symbol(8'h00);
    end_word();
    wait_drained();

    // random table, then mostly well-formed words
    for (int s = 0; s < 16; s++)
      send_request(REQ_WR_FLAG, 4'(s), 0, 0, 0, 0, 0, 0, 1'($urandom_range(0, 1)));
    n = 0;
    while (n < 85) begin
      if ($urandom_range(0, 9) == 0) begin
        write_entry($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                    $urandom);
      end else begin
        repeat ($urandom_range(0, 6)) begin
          word_symbol(likely_symbol());
          n++;
        end
        end_word();
      end
      n++;
      if (n >= 30 && !stalled) begin
        // receiver stall while requests keep coming
        stalled = 1;
        hold_results = 1;
        fork
          begin repeat (150) @(negedge clk_i); hold_results = 0; end
        join_none
      end
      if (n >= 55 && !paused) begin
        paused = 1;
        wait_drained();
      end
      if (n >= 70) calm = 1;
      // early table fill so words get somewhere
      if (n < 30)
        write_entry($urandom_range(0, 3), $urandom_range(0, 7), 1, $urandom_range(0, 15),
                    $urandom_range(0, 3), $urandom_range(0, 5), $urandom);
    end
    end_word();

    // drain and finish
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
